// File: src/round_robin_task_scheduler_core_defines.svh
// Assertion macros for the round-robin task scheduler core.
// Included by files that carry concurrent assertions; needs no package.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler core.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    // Task status codes.
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_DEAD    = 2'd3;

    // Operation codes.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_EXIT = 2'd2;

    // Result codes.
    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_FULL    = 2'd1;
    localparam logic [1:0] RC_REFUSED = 2'd2;

    // Kind of result the datapath builds.
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ADD_OK  = 3'd0;
    localparam t_kind KIND_FULL    = 3'd1;
    localparam t_kind KIND_REFUSED = 3'd2;
    localparam t_kind KIND_NOP     = 3'd3;
    localparam t_kind KIND_RUN     = 3'd4;

    // Address select for the status write port.
    typedef logic [2:0] t_st_addr;
    localparam t_st_addr SA_CUR  = 3'd0;
    localparam t_st_addr SA_SCAN = 3'd1;
    localparam t_st_addr SA_CAND = 3'd2;
    localparam t_st_addr SA_NXT  = 3'd3;
    localparam t_st_addr SA_ZERO = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] context_word;
    } t_in;

    typedef struct packed {
        logic [63:0] context_out;
        logic [3:0]  slot_out;
        logic [1:0]  result_code;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch_in;
        logic       scan_clr;
        logic       scan_inc;
        logic       ctx_we;
        logic       ctx_at_scan;
        logic       link_we;
        logic       link_unlink;
        logic       link_rd_cand;
        logic       save_nxt;
        logic       tail_to_scan;
        logic       tail_to_cur;
        logic       cur_load;
        logic       cur_from_cand;
        logic       st_we;
        t_st_addr   st_addr;
        logic [1:0] st_val;
        logic       st_rd_cand;
        logic       kind_we;
        t_kind      kind;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       cur_zero;
        logic       cur_tail;
        logic       cur_running;
        logic       head_dead;
        logic       rd_free;
        logic       rd_dead;
        logic       cand_zero;
        logic       cand_tail;
        logic       scan_last;
    } t_sts;

endpackage

`default_nettype wire

// File: src/rrts_dp.sv
// Datapath of the scheduler: task status flops, slot registers, link and
// context memories, result formatting. Depends on rrts_pkg.
`default_nettype none

module rrts_dp #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rrts_pkg::t_cmd i_cmd,
    input  wire rrts_pkg::t_in  i_in,
    output rrts_pkg::t_sts      o_sts,
    output rrts_pkg::t_out      o_res
);

    localparam int SW = $clog2(MAX_TASKS);
    typedef logic [SW-1:0] t_slot;

    logic [1:0]      r_op;
    logic [63:0]     r_word;
    t_slot           r_cur;
    t_slot           r_tail;
    t_slot           r_scan;
    t_slot           r_nxt;
    rrts_pkg::t_kind r_kind;
    logic [1:0]      r_status [MAX_TASKS];
    logic [63:0]     r_ctx_mem [MAX_TASKS];
    t_slot           r_link_mem [MAX_TASKS];
    logic [63:0]     r_ctx_q;
    t_slot           r_link_q;

    t_slot       w_cand;
    t_slot       w_rd_slot;
    logic [1:0]  w_rd_st;
    t_slot       w_st_addr;
    t_slot       w_ctx_addr;
    t_slot       w_link_waddr;
    t_slot       w_link_wdata;
    t_slot       w_link_raddr;

    // Link values that point past the table fall back to the head.
    function automatic t_slot slot_ok(input t_slot v);
        return ({1'b0, v} < (SW+1)'(MAX_TASKS)) ? v : '0;
    endfunction

    assign w_cand    = slot_ok(r_link_q);
    assign w_rd_slot = i_cmd.st_rd_cand ? w_cand : r_scan;
    assign w_rd_st   = r_status[w_rd_slot];

    // Address select for the status write port.
    always_comb begin
        unique case (i_cmd.st_addr)
            rrts_pkg::SA_CUR:  w_st_addr = r_cur;
            rrts_pkg::SA_SCAN: w_st_addr = r_scan;
            rrts_pkg::SA_CAND: w_st_addr = w_cand;
            rrts_pkg::SA_NXT:  w_st_addr = r_nxt;
            default:           w_st_addr = '0;
        endcase
    end

    // Task status flops; reset leaves the head running and the rest free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_status[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_FREE;
            end
        end else if (i_cmd.st_we) begin
            r_status[w_st_addr] <= i_cmd.st_val;
        end
    end

    // Current and tail slot registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_tail <= '0;
        end else begin
            if (i_cmd.cur_load) begin
                r_cur <= i_cmd.cur_from_cand ? w_cand : '0;
            end
            if (i_cmd.tail_to_scan) begin
                r_tail <= r_scan;
            end else if (i_cmd.tail_to_cur) begin
                r_tail <= r_cur;
            end
        end
    end

    // Transaction latch, free-slot scan index, saved successor and result kind.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_in.operation;
            r_word <= i_in.context_word;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= SW'(1);
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.save_nxt) begin
            r_nxt <= w_cand;
        end
        if (i_cmd.kind_we) begin
            r_kind <= i_cmd.kind;
        end
    end

    // Context memory: one write port, one registered read at the current slot.
    assign w_ctx_addr = i_cmd.ctx_at_scan ? r_scan : r_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ctx_we) begin
            r_ctx_mem[w_ctx_addr] <= r_word;
        end
        r_ctx_q <= r_ctx_mem[r_cur];
    end

    // Link memory: append after the tail, or bypass a dead successor.
    assign w_link_waddr = i_cmd.link_unlink ? r_cur : r_tail;
    assign w_link_wdata = i_cmd.link_unlink ? w_cand : r_scan;
    assign w_link_raddr = i_cmd.link_rd_cand ? w_cand : r_cur;

    always_ff @(posedge i_clk) begin
        if (i_cmd.link_we) begin
            r_link_mem[w_link_waddr] <= w_link_wdata;
        end
        r_link_q <= r_link_mem[w_link_raddr];
    end

    // Status toward the controller.
    always_comb begin
        o_sts.op          = r_op;
        o_sts.cur_zero    = (r_cur == '0);
        o_sts.cur_tail    = (r_cur == r_tail);
        o_sts.cur_running = (r_status[r_cur] == rrts_pkg::ST_RUNNING);
        o_sts.head_dead   = (r_status[0] == rrts_pkg::ST_DEAD);
        o_sts.rd_free     = (w_rd_st == rrts_pkg::ST_FREE);
        o_sts.rd_dead     = (w_rd_st == rrts_pkg::ST_DEAD);
        o_sts.cand_zero   = (w_cand == '0);
        o_sts.cand_tail   = (w_cand == r_tail);
        o_sts.scan_last   = (r_scan == SW'(MAX_TASKS - 1));
    end

    // Result formatting.
    always_comb begin
        o_res = '0;
        unique case (r_kind)
            rrts_pkg::KIND_ADD_OK: begin
                o_res.slot_out    = 4'(r_scan);
                o_res.result_code = rrts_pkg::RC_OK;
            end
            rrts_pkg::KIND_FULL: begin
                o_res.result_code = rrts_pkg::RC_FULL;
            end
            rrts_pkg::KIND_REFUSED: begin
                o_res.result_code = rrts_pkg::RC_REFUSED;
            end
            rrts_pkg::KIND_NOP: begin
                o_res.slot_out    = 4'(r_cur);
                o_res.result_code = rrts_pkg::RC_OK;
            end
            rrts_pkg::KIND_RUN: begin
                o_res.context_out = r_ctx_q;
                o_res.slot_out    = 4'(r_cur);
                o_res.result_code = rrts_pkg::RC_OK;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/rrts_ctrl.sv
// Controller state machine of the scheduler: decodes each transaction and
// sequences the free-slot scan and the ring walk. Depends on rrts_pkg.
`default_nettype none

module rrts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic           i_out_free,
    input  wire rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_cmd      o_cmd,
    output logic                o_in_ready,
    output logic                o_res_valid
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WRDL = 3'd3;
    localparam logic [2:0] S_WCHK = 3'd4;
    localparam logic [2:0] S_WUNL = 3'd5;
    localparam logic [2:0] S_CRD  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.latch_in = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    rrts_pkg::OP_ADD: begin
                        n_state = S_SCAN;
                    end
                    rrts_pkg::OP_TICK: begin
                        // Save the context and put the running task back in line.
                        o_cmd.ctx_we  = 1'b1;
                        o_cmd.st_we   = 1'b1;
                        o_cmd.st_addr = rrts_pkg::SA_CUR;
                        o_cmd.st_val  = rrts_pkg::ST_READY;
                        n_state       = S_WRDL;
                    end
                    rrts_pkg::OP_EXIT: begin
                        if (i_sts.cur_zero) begin
                            o_cmd.kind_we = 1'b1;
                            o_cmd.kind    = rrts_pkg::KIND_REFUSED;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_addr = rrts_pkg::SA_CUR;
                            o_cmd.st_val  = rrts_pkg::ST_DEAD;
                            n_state       = S_WRDL;
                        end
                    end
                    default: begin
                        o_cmd.kind_we = 1'b1;
                        o_cmd.kind    = rrts_pkg::KIND_NOP;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // One slot per cycle, lowest free slot above the head wins.
                if (i_sts.rd_free) begin
                    o_cmd.st_we        = 1'b1;
                    o_cmd.st_addr      = rrts_pkg::SA_SCAN;
                    o_cmd.st_val       = rrts_pkg::ST_READY;
                    o_cmd.ctx_we       = 1'b1;
                    o_cmd.ctx_at_scan  = 1'b1;
                    o_cmd.link_we      = 1'b1;
                    o_cmd.tail_to_scan = 1'b1;
                    o_cmd.kind_we      = 1'b1;
                    o_cmd.kind         = rrts_pkg::KIND_ADD_OK;
                    n_state            = S_DONE;
                end else if (i_sts.scan_last) begin
                    o_cmd.kind_we = 1'b1;
                    o_cmd.kind    = rrts_pkg::KIND_FULL;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_WRDL: begin
                // The tail wraps to the head; otherwise fetch the successor link.
                if (i_sts.cur_tail) begin
                    o_cmd.cur_load = 1'b1;
                    o_cmd.st_we    = 1'b1;
                    o_cmd.st_addr  = rrts_pkg::SA_ZERO;
                    o_cmd.st_val   = rrts_pkg::ST_RUNNING;
                    n_state        = S_CRD;
                end else begin
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                o_cmd.st_rd_cand = 1'b1;
                if (i_sts.cand_zero || !i_sts.rd_dead) begin
                    o_cmd.cur_load      = 1'b1;
                    o_cmd.cur_from_cand = 1'b1;
                    o_cmd.st_we         = 1'b1;
                    o_cmd.st_addr       = rrts_pkg::SA_CAND;
                    o_cmd.st_val        = rrts_pkg::ST_RUNNING;
                    n_state             = S_CRD;
                end else if (i_sts.cand_tail) begin
                    // Dead tail: the current slot becomes the tail.
                    o_cmd.tail_to_cur = 1'b1;
                    o_cmd.st_we       = 1'b1;
                    o_cmd.st_addr     = rrts_pkg::SA_CAND;
                    o_cmd.st_val      = rrts_pkg::ST_FREE;
                    n_state           = S_WRDL;
                end else begin
                    o_cmd.save_nxt     = 1'b1;
                    o_cmd.link_rd_cand = 1'b1;
                    n_state            = S_WUNL;
                end
            end
            S_WUNL: begin
                // Bypass the dead successor and free it.
                o_cmd.link_we     = 1'b1;
                o_cmd.link_unlink = 1'b1;
                o_cmd.st_we       = 1'b1;
                o_cmd.st_addr     = rrts_pkg::SA_NXT;
                o_cmd.st_val      = rrts_pkg::ST_FREE;
                n_state           = S_WRDL;
            end
            S_CRD: begin
                o_cmd.kind_we = 1'b1;
                o_cmd.kind    = rrts_pkg::KIND_RUN;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/round_robin_task_scheduler_core.sv
// Top level of the round-robin task scheduler: controller, datapath and the
// output register. Depends on rrts_pkg, rrts_ctrl, rrts_dp and the defines header.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_ready      i_in_data  (rrts_pkg::t_in)
//   result    out        o_out_valid / i_out_ready    o_out_data (rrts_pkg::t_out)
//
// One transaction at a time. Add runs the free-slot scan, which visits slots upward
// from 1 to at most MAX_TASKS-1. Tick and exit walk the ring, either wrapping from the
// tail to the head or stopping at a linked task, and free dead tasks on the way; a dead
// tail makes the current slot the tail. Refused exit and unused codes end after decode.
// A new transaction is taken while a result waits in the output register; a stalled
// result holds the controller in its last state. Reset is synchronous; memories keep data.
`default_nettype none
`include "round_robin_task_scheduler_core_defines.svh"

module round_robin_task_scheduler_core #(
    parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rrts_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rrts_pkg::t_out     o_out_data
);

    rrts_pkg::t_cmd w_cmd;
    rrts_pkg::t_sts w_sts;
    rrts_pkg::t_out w_res;
    logic           w_accept;
    logic           w_out_free;
    logic           w_res_valid;
    logic           w_load;
    logic           r_out_valid;
    rrts_pkg::t_out r_out_data;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = w_res_valid && w_out_free;

    rrts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_out_free  (w_out_free),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_res_valid (w_res_valid)
    );

    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_in    (i_in_data),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    // Output register between the controller and the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A transaction always passes through the decode state before its result is ready.
    `RRTS_ASSERT_NXT(a_no_early_result, i_clk, i_rst_n, w_accept, !w_res_valid, "early result")
    // Between transactions the current slot is the one marked running.
    `RRTS_ASSERT_IMP(a_cur_running, i_clk, i_rst_n, o_in_ready, w_sts.cur_running, "idle, not running")
    // The head task can never be marked dead, so every walk terminates.
    `RRTS_ASSERT_IMP(a_head_alive, i_clk, i_rst_n, 1'b1, !w_sts.head_dead, "head slot marked dead")

endmodule

`default_nettype wire

// File: tb/sv/round_robin_task_scheduler_core_tb.sv
// Self-checking testbench for the round-robin task scheduler core.
// Needs rrts_pkg and round_robin_task_scheduler_core; it holds its own model of the task ring.
`timescale 1ns / 100ps

module round_robin_task_scheduler_core_tb;
    import rrts_pkg::*;

    localparam int TASK_SLOTS = MAX_TASKS_DEF;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 4;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int MIX_RUN = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT = 1_000_000;

    // The operation code that the block treats as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Operation mixes for the random part.
    localparam int MIX_FILL = 0;
    localparam int MIX_CHURN = 1;
    localparam int MIX_DRAIN = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in in_data = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // Requests waiting to be offered, and results the model says must come back.
    t_in pending_requests[$];
    t_out expected_results[$];

    // Model of the scheduler state.
    logic [63:0] slot_ctx [TASK_SLOTS];
    logic [1:0] slot_state [TASK_SLOTS];
    logic [3:0] slot_link [TASK_SLOTS];
    logic [3:0] tail_slot;
    logic [3:0] run_slot;

    // Idle settings, hold-off requests and run statistics.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int add_count = 0;
    int tick_count = 0;
    int exit_count = 0;
    int unused_count = 0;
    int full_count = 0;
    int refused_count = 0;
    int swept_count = 0;
    int results_seen = 0;

    round_robin_task_scheduler_core dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Put the model in its reset state: only the kernel task, running.
    function automatic void clear_schedule();
        for (int s = 0; s < TASK_SLOTS; s++) begin
            slot_ctx[s] = '0;
            slot_state[s] = ST_FREE;
            slot_link[s] = '0;
        end
        slot_state[0] = ST_RUNNING;
        tail_slot = '0;
        run_slot = '0;
    endfunction

    // Walk forward from the running slot, freeing dead tasks on the way.
    function automatic void advance_to_next_task();
        logic [3:0] prev;
        logic [3:0] nxt;
        for (int guard = 0; guard <= TASK_SLOTS; guard++) begin
            prev = run_slot;
            nxt = (prev == tail_slot) ? 4'd0 : slot_link[prev];
            if (nxt != 4'd0 && slot_state[nxt] == ST_DEAD) begin
                if (nxt == tail_slot) begin
                    tail_slot = prev;
                end else begin
                    slot_link[prev] = slot_link[nxt];
                end
                slot_state[nxt] = ST_FREE;
                swept_count++;
            end else begin
                run_slot = nxt;
                slot_state[nxt] = ST_RUNNING;
                return;
            end
        end
        run_slot = '0;
        slot_state[0] = ST_RUNNING;
    endfunction

    // Apply one request to the model and return the result it must produce.
    function automatic t_out compute_schedule_result(t_in req);
        t_out res;
        logic found;
        logic [3:0] free_slot;
        res = '0;
        res.result_code = RC_OK;
        found = 1'b0;
        free_slot = '0;
        case (req.operation)
            OP_ADD: begin
                add_count++;
                for (int s = TASK_SLOTS - 1; s >= 1; s--) begin
                    if (slot_state[s] == ST_FREE) begin
                        found = 1'b1;
                        free_slot = 4'(s);
                    end
                end
                if (found) begin
                    slot_state[free_slot] = ST_READY;
                    slot_ctx[free_slot] = req.context_word;
                    slot_link[tail_slot] = free_slot;
                    tail_slot = free_slot;
                    res.slot_out = free_slot;
                end else begin
                    res.result_code = RC_FULL;
                    full_count++;
                end
            end
            OP_TICK: begin
                tick_count++;
                slot_ctx[run_slot] = req.context_word;
                if (slot_state[run_slot] != ST_DEAD) begin
                    slot_state[run_slot] = ST_READY;
                end
                advance_to_next_task();
                res.context_out = slot_ctx[run_slot];
                res.slot_out = run_slot;
            end
            OP_EXIT: begin
                exit_count++;
                if (run_slot == 4'd0) begin
                    res.result_code = RC_REFUSED;
                    refused_count++;
                end else begin
                    slot_state[run_slot] = ST_DEAD;
                    advance_to_next_task();
                    res.context_out = slot_ctx[run_slot];
                    res.slot_out = run_slot;
                end
            end
            default: begin
                unused_count++;
                res.slot_out = run_slot;
            end
        endcase
        return res;
    endfunction

    function automatic t_in build_request(logic [1:0] op, logic [63:0] word);
        t_in req;
        req.operation = op;
        req.context_word = word;
        return req;
    endfunction

    // A random request; the mix decides whether tasks pile up, churn or die off.
    function automatic t_in random_request(int mix);
        int roll;
        int add_w;
        int tick_w;
        int exit_w;
        logic [1:0] op;
        logic [63:0] word;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: begin
                add_w = 60;
                tick_w = 25;
                exit_w = 10;
            end
            MIX_CHURN: begin
                add_w = 25;
                tick_w = 45;
                exit_w = 25;
            end
            default: begin
                add_w = 10;
                tick_w = 40;
                exit_w = 45;
            end
        endcase
        if (roll < add_w) begin
            op = OP_ADD;
        end else if (roll < add_w + tick_w) begin
            op = OP_TICK;
        end else if (roll < add_w + tick_w + exit_w) begin
            op = OP_EXIT;
        end else begin
            op = OP_UNUSED;
        end
        case ($urandom_range(0, 15))
            0: word = '0;
            1: word = '1;
            default: word = {$urandom, $urandom};
        endcase
        return build_request(op, word);
    endfunction

    // Wait until every queued request has been taken and every result returned.
    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Driver: offers queued requests and predicts each accepted transaction.
    always @(posedge clk) begin
        if (!rst_n) begin
            clear_schedule();
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(compute_schedule_result(in_data));
            end
            if (!in_valid || in_ready) begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pending_requests.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each returned transaction and drives the result-side ready.
    always @(posedge clk) begin
        t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("Result with nothing expected: context_out %h slot_out %0d code %0d",
                           out_data.context_out, out_data.slot_out, out_data.result_code);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.context_out !== want.context_out) begin
                        $error("context_out: expected %h, actual %h",
                               want.context_out, out_data.context_out);
                        error_count++;
                    end
                    if (out_data.slot_out !== want.slot_out) begin
                        $error("slot_out: expected %0d, actual %0d",
                               want.slot_out, out_data.slot_out);
                        error_count++;
                    end
                    if (out_data.result_code !== want.result_code) begin
                        $error("result_code: expected %0d, actual %0d",
                               want.result_code, out_data.result_code);
                        error_count++;
                    end
                end
            end
            // A hold-off request overrides the random stalls for a long stretch.
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus: a directed opening, then four random phases with different idling.
    initial begin
        logic [63:0] word;
        int mix;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Exit of the kernel task is refused; the unused code changes nothing.
        pending_requests.push_back(build_request(OP_EXIT, '1));
        pending_requests.push_back(build_request(OP_UNUSED, '1));
        // A tick with only the kernel task hands the kernel back its own context.
        pending_requests.push_back(build_request(OP_TICK, '1));
        // Fill every slot, then one more add finds the table full.
        for (int i = 0; i < TASK_SLOTS - 1; i++) begin
            case (i)
                0: word = '0;
                1: word = '1;
                2: word = {32{2'b01}};
                3: word = {32{2'b10}};
                default: word = {$urandom, $urandom};
            endcase
            pending_requests.push_back(build_request(OP_ADD, word));
        end
        pending_requests.push_back(build_request(OP_ADD, {$urandom, $urandom}));
        // A dead task that no walk has passed yet still blocks its slot.
        pending_requests.push_back(build_request(OP_TICK, '0));
        pending_requests.push_back(build_request(OP_EXIT, '0));
        pending_requests.push_back(build_request(OP_ADD, '1));
        pending_requests.push_back(build_request(OP_EXIT, {$urandom, $urandom}));
        pending_requests.push_back(build_request(OP_TICK, {$urandom, $urandom}));
        wait_until_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 69;
                end
                default: begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            mix = MIX_FILL;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % MIX_RUN == 0) begin
                    mix = $urandom_range(MIX_FILL, MIX_DRAIN);
                end
                pending_requests.push_back(random_request(mix));
            end
            // The receiver holds off while the sender keeps offering, so the core backs up.
            if (phase == 0) begin
                hold_requests++;
            end
            wait_until_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results: %0d adds (%0d table full), %0d ticks, %0d exits",
                 results_seen, add_count, full_count, tick_count, exit_count);
        $display("(%0d refused at the kernel task), %0d unused codes, %0d dead tasks swept.",
                 refused_count, unused_count, swept_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
